FILE: sv/lcgs_pkg.sv
package lcgs_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam int LEN_CFG_W  = 10;
	localparam int CNT_CFG_W  = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_LENGTH = 1'd0,
		REG_LINE_COUNT  = 1'd1
	} cfg_reg_t;

	localparam logic [LEN_CFG_W-1:0] LINE_LENGTH_RESET = 10'd480;
	localparam logic [CNT_CFG_W-1:0] LINE_COUNT_RESET  = 11'd640;

	// stream payload widths
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 8;

	// 3x3 window: bit 0 top, bit 1 middle, bit 2 bottom of a column;
	// newest (right) column in the lowest bits
	localparam int COL_BITS   = 3;
	localparam int WIN_W      = 9;
	localparam int CHAIN_LEN  = 2;
	localparam int CENTER_BIT = 4;

	localparam logic [WIN_W-1:0] MASK_LEFT   = 9'h1C0;
	localparam logic [WIN_W-1:0] MASK_RIGHT  = 9'h007;
	localparam logic [WIN_W-1:0] MASK_TOP    = 9'h049;
	localparam logic [WIN_W-1:0] MASK_BOTTOM = 9'h124;

	// line store word: bit 0 upper line, bit 1 middle line
	localparam int STORE_W = 2;

	// output queue
	localparam int OQ_DEPTH = 3;
	localparam int OQ_PTR_W = 2;
	localparam int OQ_CNT_W = 2;

	// per-request control handed from the counter front end to the window stage
	typedef struct packed {
		logic             cur_cell;
		logic             emit;
		logic             last;
		logic [WIN_W-1:0] mask;
	} step_ctl_t;

endpackage

FILE: sv/lcgs_ram.sv
module lcgs_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read-first: a read at the address being written returns the old word
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/lcgs_col_cell.sv
module lcgs_col_cell import lcgs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  logic                clear,
	input  logic [COL_BITS-1:0] col_in,
	output logic [COL_BITS-1:0] col_out
);

	logic [COL_BITS-1:0] col_q;

	// take the neighbor's column on every shift, drop to dead at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= clear ? '0 : col_in;
		end
	end

	assign col_out = col_q;

endmodule

FILE: sv/lcgs_ctrl.sv
module lcgs_ctrl import lcgs_pkg::*; #(
	parameter int MAX_LINE_LEN = 512,
	parameter int MAX_LINES    = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [CFG_IDX_W-1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0]           cfg_data,
	input  logic                            accept,
	input  logic                            kind,
	input  logic                            alive,
	output logic [$clog2(MAX_LINE_LEN)-1:0] addr,
	output step_ctl_t                       ctl
);

	localparam int COL_W      = $clog2(MAX_LINE_LEN);
	localparam int LEN_W      = $clog2(MAX_LINE_LEN + 1) + 1;
	localparam int IN_LINE_W  = $clog2(MAX_LINES + 1);
	localparam int LINES_W    = $clog2(MAX_LINES + 1) + 1;
	localparam int OUT_LINE_W = $clog2(MAX_LINES);

	logic [LEN_CFG_W-1:0]  line_length_q;
	logic [CNT_CFG_W-1:0]  line_count_q;
	logic [COL_W-1:0]      in_column_q;
	logic [IN_LINE_W-1:0]  in_line_q;
	logic [COL_W-1:0]      out_column_q;
	logic [OUT_LINE_W-1:0] out_line_q;

	logic [LEN_W-1:0]   len;
	logic [LINES_W-1:0] lines;
	logic               in_col_end;
	logic               in_past_grid;
	logic               out_col_end;
	logic               out_row_end;
	logic               emit;
	logic               last;
	logic [WIN_W-1:0]   mask;

	always_comb begin
		if (line_length_q == '0) begin
			len = LEN_W'(1);
		end else if (32'(line_length_q) > 32'(MAX_LINE_LEN)) begin
			len = LEN_W'(MAX_LINE_LEN);
		end else begin
			len = LEN_W'(line_length_q);
		end
		if (line_count_q == '0) begin
			lines = LINES_W'(1);
		end else if (32'(line_count_q) > 32'(MAX_LINES)) begin
			lines = LINES_W'(MAX_LINES);
		end else begin
			lines = LINES_W'(line_count_q);
		end
	end

	assign in_col_end   = (LEN_W'(in_column_q) + LEN_W'(1)) >= len;
	assign in_past_grid = LINES_W'(in_line_q) >= lines;
	assign out_col_end  = (LEN_W'(out_column_q) + LEN_W'(1)) >= len;
	assign out_row_end  = (LINES_W'(out_line_q) + LINES_W'(1)) >= lines;

	assign emit = (in_line_q >= IN_LINE_W'(2)) || (in_line_q != '0 && in_column_q != '0);
	assign last = emit && out_row_end && out_col_end;

	always_comb begin
		mask = '1;
		if (out_column_q == '0) begin
			mask = mask & ~MASK_LEFT;
		end
		if (out_col_end) begin
			mask = mask & ~MASK_RIGHT;
		end
		if (out_line_q == '0) begin
			mask = mask & ~MASK_TOP;
		end
		if (out_row_end) begin
			mask = mask & ~MASK_BOTTOM;
		end
	end

	assign addr         = in_column_q;
	assign ctl.cur_cell = alive & ~kind & ~in_past_grid;
	assign ctl.emit     = emit;
	assign ctl.last     = last;
	assign ctl.mask     = mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LINE_LENGTH_RESET;
			line_count_q  <= LINE_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LINE_LENGTH: line_length_q <= cfg_data[LEN_CFG_W-1:0];
				REG_LINE_COUNT:  line_count_q  <= cfg_data[CNT_CFG_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_column_q  <= '0;
			in_line_q    <= '0;
			out_column_q <= '0;
			out_line_q   <= '0;
		end else if (accept) begin
			if (last) begin
				in_column_q  <= '0;
				in_line_q    <= '0;
				out_column_q <= '0;
				out_line_q   <= '0;
			end else begin
				if (in_col_end) begin
					in_column_q <= '0;
					if (in_line_q != '1) begin
						in_line_q <= in_line_q + 1'b1;
					end
				end else begin
					in_column_q <= in_column_q + 1'b1;
				end
				if (emit) begin
					if (out_col_end) begin
						out_column_q <= '0;
						if (out_line_q != '1) begin
							out_line_q <= out_line_q + 1'b1;
						end
					end else begin
						out_column_q <= out_column_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

FILE: sv/life_cell_generation_stencil.sv
// Game of Life generation stencil, rule B3/S23. Cells of one generation enter in
// line order on the s_ stream, one per clock while s_tready is high, and the
// next-generation state of each cell leaves on the m_ stream one line plus one
// cell later, in the same order, with m_tlast on the last cell of the grid.
// Cells outside the grid count as dead. After the last grid cell, send
// line_length + 1 flush requests (tuser high) so the final line drains; the
// counters and window then return to zero and the next frame may start. The
// block takes one request per clock while s_tready is high, and the line store
// memory is read and written once per request. A result enters the output
// queue in the cycle after its input request is taken and can leave in the
// cycle after that. After reset the line store memory is cleared, one address
// a clock, from address 0 to MAX_LINE_LEN - 1; s_tready stays low during that
// pass, while configuration writes are taken at any time. Write line_length
// and line_count only while the block is idle; zero reads as one and larger
// values saturate at MAX_LINE_LEN and MAX_LINES.
module life_cell_generation_stencil import lcgs_pkg::*; #(
	parameter int MAX_LINE_LEN = 512,
	parameter int MAX_LINES    = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input cells
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // [0] alive, rest zero
	input  logic                  s_tuser,   // [0] kind: 1 is a flush request
	// next-generation cells
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // [0] next_alive, rest zero
	output logic                  m_tlast,   // frame_last
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int COL_W = $clog2(MAX_LINE_LEN);

	// ---------------------------------------------------------------------
	// Line store clearing pass after reset
	// ---------------------------------------------------------------------
	logic             clr_busy_q;
	logic [COL_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == COL_W'(MAX_LINE_LEN - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// ---------------------------------------------------------------------
	// Front end: counters, edge masks and frame end, evaluated at accept
	// ---------------------------------------------------------------------
	logic             accept;
	logic [COL_W-1:0] req_addr;
	step_ctl_t        req_ctl;

	assign accept = s_tvalid & s_tready;

	lcgs_ctrl #(
		.MAX_LINE_LEN(MAX_LINE_LEN),
		.MAX_LINES   (MAX_LINES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.kind     (s_tuser),
		.alive    (s_tdata[0]),
		.addr     (req_addr),
		.ctl      (req_ctl)
	);

	// ---------------------------------------------------------------------
	// Stage 1: line store read data arrives, column forms, window advances
	// ---------------------------------------------------------------------
	logic               valid_s1;
	logic [COL_W-1:0]   addr_s1;
	step_ctl_t          ctl_s1;
	logic               fwd_s1;
	logic [STORE_W-1:0] fwd_data_s1;

	logic [STORE_W-1:0] ram_rdata;
	logic [STORE_W-1:0] rd_word;
	logic [STORE_W-1:0] wr_word;
	logic               top_cell;
	logic               mid_cell;
	logic [COL_BITS-1:0] col;

	// The memory reads before it writes, so a request that reads the column
	// stage 1 is writing in the same clock takes the new word from a bypass.
	assign rd_word  = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign top_cell = rd_word[0];
	assign mid_cell = rd_word[1];
	// middle line moves up, the new cell becomes the middle line
	assign wr_word  = {ctl_s1.cur_cell, mid_cell};
	assign col      = {ctl_s1.cur_cell, mid_cell, top_cell};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				fwd_s1 <= valid_s1 && (addr_s1 == req_addr);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1     <= req_addr;
			ctl_s1      <= req_ctl;
			fwd_data_s1 <= wr_word;
		end
	end

	lcgs_ram #(
		.WIDTH(STORE_W),
		.DEPTH(MAX_LINE_LEN)
	) u_line_store (
		.clk  (clk),
		.we   (clr_busy_q | valid_s1),
		.waddr(clr_busy_q ? clr_addr_q : addr_s1),
		.wdata(clr_busy_q ? '0 : wr_word),
		.re   (accept),
		.raddr(req_addr),
		.rdata(ram_rdata)
	);

	// Window: the newest column comes straight from stage 1, the two older
	// columns live in a chain of column cells that shift once per request.
	logic [COL_BITS-1:0] chain [CHAIN_LEN];
	logic [WIN_W-1:0]    win;

	for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
		lcgs_col_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (valid_s1),
			.clear  (ctl_s1.last),
			.col_in (k == 0 ? col : chain[(k == 0) ? 0 : k - 1]),
			.col_out(chain[k])
		);
	end

	always_comb begin
		win[COL_BITS-1:0] = col;
		for (int k = 0; k < CHAIN_LEN; k++) begin
			win[COL_BITS*(k+1) +: COL_BITS] = chain[k];
		end
	end

	// B3/S23 on the masked neighborhood
	logic [WIN_W-1:0] nbr;
	logic [3:0]       n_alive;
	logic             next_alive;

	assign nbr = win & ctl_s1.mask;

	always_comb begin
		n_alive = '0;
		for (int i = 0; i < WIN_W; i++) begin
			if (i != CENTER_BIT) begin
				n_alive = n_alive + 4'(nbr[i]);
			end
		end
		if (n_alive == 4'd3) begin
			next_alive = 1'b1;
		end else if (n_alive == 4'd2) begin
			next_alive = win[CENTER_BIT];
		end else begin
			next_alive = 1'b0;
		end
	end

	// ---------------------------------------------------------------------
	// Output queue: parts the window stage from downstream back-pressure
	// ---------------------------------------------------------------------
	logic [1:0]          oq_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_wr_q;
	logic [OQ_PTR_W-1:0] oq_rd_q;
	logic [OQ_CNT_W-1:0] oq_cnt_q;
	logic                oq_push;
	logic                oq_pop;

	assign oq_push  = valid_s1 & ctl_s1.emit;
	assign oq_pop   = m_tvalid & m_tready;
	assign m_tvalid = oq_cnt_q != '0;
	assign m_tdata  = M_TDATA_W'(oq_q[oq_rd_q][0]);
	assign m_tlast  = oq_q[oq_rd_q][1];

	// accept only while the queue has room for stage 1 and the new request
	assign s_tready = !clr_busy_q &&
		(({1'b0, oq_cnt_q} + (OQ_CNT_W+1)'(oq_push)) <= (OQ_CNT_W+1)'(OQ_DEPTH - 1));

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[oq_wr_q] <= {ctl_s1.last, next_alive};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= (oq_wr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= (oq_rd_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_rd_q + 1'b1;
			end
			if (oq_push && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + 1'b1;
			end else if (!oq_push && oq_pop) begin
				oq_cnt_q <= oq_cnt_q - 1'b1;
			end
		end
	end

endmodule
